// ===== rtl/core/qsm_pkg.sv =====
// Package for the QAM symbol mapper: queue entry type, unpack phase codes,
// default queue depth and the Gray amplitude mapping function.
// Depends on nothing; every other file of the block but qsm_checker uses it.
package qsm_pkg;

  // Default depth of the queue between the unpack front and the mapping back.
  localparam int unsigned QueueDepth = 4;

  // Unpack phase inside a QAM64 group of three bytes.
  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_t;

  // One classified byte: one or two symbols waiting to be mapped.
  typedef struct packed {
    logic [7:0] sym0;  // first symbol; only the low six bits count in QAM64
    logic [5:0] sym1;  // second symbol of a byte that closes a QAM64 group
    logic       two;   // the byte yields two symbols
    logic       wide;  // 8-bit symbols (QAM256)
  } entry_t;

  typedef struct packed {
    logic signed [4:0] re;
    logic signed [4:0] im;
  } amp_t;

  // Gray mapping: for each bit pair from the low pair upward, both axes step
  // down by the next power of two and flip sign when their bit is zero.
  function automatic amp_t map_symbol(input logic [7:0] sym, input logic wide);
    logic signed [5:0] r;
    logic signed [5:0] q;
    logic signed [5:0] step;
    amp_t              res;
    r    = '0;
    q    = '0;
    step = 6'sd1;
    for (int j = 0; j < 4; j++) begin
      if ((j < 3) || wide) begin
        r    = r - step;
        q    = q - step;
        step = step <<< 1;
        if (!sym[2*j+1]) begin
          r = -r;
        end
        if (!sym[2*j]) begin
          q = -q;
        end
      end
    end
    res.re = r[4:0];
    res.im = q[4:0];
    return res;
  endfunction

endpackage

// ===== rtl/core/qam_symbol_mapper.sv =====
// Top level of the QAM64 / QAM256 Gray symbol mapper.
// Depends on qsm_pkg, qsm_front, qsm_queue and qsm_back.
//
// Usage: bytes of packed bits, most significant bit first, enter through
// push / full with in_data_byte and in_end_of_block; a byte is taken at a
// clock edge with push high and full low. Symbols leave through empty / pop:
// while empty is low the oldest symbol stands on out_real_part,
// out_imag_part and out_last_of_item, and pop takes it.
// cfg_wr_en with cfg_wr_data selects the mode (0 = QAM64, 1 = QAM256);
// write it only while the block is idle.
// The first symbol of a byte passes through a queue slot and then the
// output register. Throughput: while the receiver pops, the back part
// maps one symbol per cycle, so QAM256 takes one byte every cycle and
// QAM64 fewer, the byte that closes a group of three giving two symbols.
// The queue between front and back (QUEUE_DEPTH entries) absorbs bursts;
// when the receiver stops popping, the queue fills and full rises.
// Reset (rst_n low, synchronous) empties the queue and output register,
// sets QAM256 mode and clears the QAM64 unpack phase and leftover bits.
module qam_symbol_mapper #(
  parameter int unsigned QUEUE_DEPTH = qsm_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_block,
  output logic              empty,
  input  logic              pop,
  output logic signed [4:0] out_real_part,
  output logic signed [4:0] out_imag_part,
  output logic              out_last_of_item
);

  qsm_pkg::entry_t new_entry;
  qsm_pkg::entry_t head_entry;
  logic            accept;
  logic            q_empty;
  logic            head_pop;

  assign accept = push && !full;

  qsm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .end_of_block (in_end_of_block),
    .entry        (new_entry)
  );

  qsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_entry (new_entry),
    .rd_en    (head_pop),
    .rd_entry (head_entry),
    .full     (full),
    .empty    (q_empty)
  );

  qsm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head_entry),
    .head_valid   (!q_empty),
    .head_pop     (head_pop),
    .empty        (empty),
    .pop          (pop),
    .real_part    (out_real_part),
    .imag_part    (out_imag_part),
    .last_of_item (out_last_of_item)
  );

endmodule

// ===== rtl/core/qsm_front.sv =====
// Front part of the QAM symbol mapper: holds the mode register and the
// QAM64 unpack state, and turns each accepted byte into one queue entry.
// Depends on qsm_pkg.
module qsm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_block,
  output qsm_pkg::entry_t      entry
);

  logic              mode_r;
  qsm_pkg::phase_t   phase_r, phase_nxt;
  logic [3:0]        left_r, left_nxt;

  always_comb begin
    entry      = '0;
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    if (mode_r) begin
      entry.sym0 = data_byte;
      entry.wide = 1'b1;
    end else begin
      case (phase_r)
        qsm_pkg::PH_1: begin
          entry.sym0 = {2'b00, left_r[1:0], data_byte[7:4]};
          left_nxt   = data_byte[3:0];
          phase_nxt  = qsm_pkg::PH_2;
        end
        qsm_pkg::PH_2: begin
          entry.sym0 = {2'b00, left_r, data_byte[7:6]};
          entry.sym1 = data_byte[5:0];
          entry.two  = 1'b1;
          left_nxt   = '0;
          phase_nxt  = qsm_pkg::PH_0;
        end
        default: begin
          entry.sym0 = {2'b00, data_byte[7:2]};
          left_nxt   = {2'b00, data_byte[1:0]};
          phase_nxt  = qsm_pkg::PH_1;
        end
      endcase
    end
    if (end_of_block) begin
      left_nxt  = '0;
      phase_nxt = qsm_pkg::PH_0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      phase_r <= qsm_pkg::PH_0;
      left_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        left_r  <= left_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/qsm_queue.sv =====
// Short queue of classified bytes between the unpack front and the mapping
// back of the QAM symbol mapper. Depends on qsm_pkg.
module qsm_queue #(
  parameter int unsigned DEPTH = qsm_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  qsm_pkg::entry_t wr_entry,
  input  logic            rd_en,
  output qsm_pkg::entry_t rd_entry,
  output logic            full,
  output logic            empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  qsm_pkg::entry_t     slot_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;
  logic                do_wr, do_rd;

  assign full     = (count_r == FullCnt);
  assign empty    = (count_r == '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && !empty;
  assign rd_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/qsm_back.sv =====
// Back part of the QAM symbol mapper: takes queue entries, maps one symbol
// per cycle, while its output is free or popped, to Gray amplitudes and
// holds it in the output register. Depends on qsm_pkg.
module qsm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  qsm_pkg::entry_t   head,
  input  logic              head_valid,
  output logic              head_pop,
  output logic              empty,
  input  logic              pop,
  output logic signed [4:0] real_part,
  output logic signed [4:0] imag_part,
  output logic              last_of_item
);

  logic              out_valid_r;
  logic              second_r;
  logic signed [4:0] re_r, im_r;
  logic              last_r;
  logic              load;
  logic [7:0]        sym;
  qsm_pkg::amp_t     amp;

  // The output register frees up when it is empty or being popped.
  assign load     = head_valid && (!out_valid_r || pop);
  assign head_pop = load && (!head.two || second_r);
  assign sym      = second_r ? {2'b00, head.sym1} : head.sym0;
  assign amp      = qsm_pkg::map_symbol(sym, head.wide);

  always_ff @(posedge clk) begin
    if (load) begin
      re_r   <= amp.re;
      im_r   <= amp.im;
      last_r <= !head.two || second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        second_r    <= head.two && !second_r;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty        = !out_valid_r;
  assign real_part    = re_r;
  assign imag_part    = im_r;
  assign last_of_item = last_r;

endmodule

// ===== rtl/core/qsm_checker.sv =====
// Port-level checks for the QAM symbol mapper, bound to the top level.
// Depends on qam_symbol_mapper's ports only.
module qsm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic signed [4:0] out_real_part,
  input logic signed [4:0] out_imag_part,
  input logic              out_last_of_item
);

  // Reset leaves no symbol waiting and room for input.
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> empty)
    else $error("symbol shown right after reset");

  a_reset_room : assert property (@(posedge clk) !rst_n |=> !full)
    else $error("full right after reset");

  // Every amplitude the mapper gives is an odd integer.
  a_odd_amp : assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_real_part[0] && out_imag_part[0]))
    else $error("even amplitude on the result ports");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_real_part) &&
                          $stable(out_imag_part) && $stable(out_last_of_item)))
    else $error("stalled symbol changed");

endmodule

bind qam_symbol_mapper qsm_checker u_qsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_real_part    (out_real_part),
  .out_imag_part    (out_imag_part),
  .out_last_of_item (out_last_of_item)
);
